// ===== sv/mlfq_pkg.sv =====
package mlfq_pkg;

	// Defaults for the top-level parameters.
	localparam int SLOTS_DEF     = 8;
	localparam int TOP_LEVEL_DEF = 7;

	// Fixed field widths.
	localparam int TIME_W  = 16;
	localparam int WORK_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int LVL_W   = 3;
	localparam int SLICE_W = 8;
	// Slot index inside the chain; wide enough for the largest slot count (16).
	localparam int IDX_W   = 5;

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Scan token handed from cell to cell.
	typedef struct packed {
		logic [IDX_W-1:0] idx;      // candidate slot, 0 if none
		logic [LVL_W-1:0] lvl;      // level of the candidate
		logic             any_run;  // at least one runnable slot seen
		logic             multi;    // more than one runnable slot seen
		logic             all_fin;  // no slot seen so far has work left
	} tok_t;

	// Tick context, stable for the whole scan.
	typedef struct packed {
		logic              held;
		logic [IDX_W-1:0]  held_idx;
		logic [TIME_W-1:0] t;
	} ctx_t;

	// Load broadcast.
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] arrival;
		logic [WORK_W-1:0] burst;
	} load_t;

	// Run broadcast to the chosen cell.
	typedef struct packed {
		logic             go;
		logic [IDX_W-1:0] idx;
		logic             multi;
	} run_t;

endpackage

// ===== sv/mlfq_cell.sv =====
module mlfq_cell #(
	parameter int TOP_LEVEL = mlfq_pkg::TOP_LEVEL_DEF,
	parameter int IDX       = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_vld_i,
	input  mlfq_pkg::tok_t  tok_i,
	input  mlfq_pkg::ctx_t  ctx,
	input  mlfq_pkg::load_t load,
	input  mlfq_pkg::run_t  run,
	output logic            tok_vld_o,
	output mlfq_pkg::tok_t  tok_o,
	output logic            yield_o
);

	localparam logic [mlfq_pkg::IDX_W-1:0] MINE = mlfq_pkg::IDX_W'(IDX);

	logic [mlfq_pkg::TIME_W-1:0]  arr_q;
	logic [mlfq_pkg::WORK_W-1:0]  rem_q;
	logic [mlfq_pkg::LVL_W-1:0]   lvl_q;
	logic [mlfq_pkg::SLICE_W-1:0] slice_q;
	logic                         hungry_q;
	logic                         vld_q;
	mlfq_pkg::tok_t               tok_q;

	logic                         arrived, work, now, mark, hungry_m, rn;
	logic                         load_hit, sel, yield_c, demote;
	logic [mlfq_pkg::WORK_W-1:0]  rem_n;
	logic [mlfq_pkg::SLICE_W-1:0] slice_n;
	mlfq_pkg::tok_t               tok_n;

	always_comb begin
		arrived  = ctx.t >= arr_q;
		work     = rem_q != '0;
		now      = (ctx.t == arr_q) && work;
		mark     = !ctx.held && arrived && (ctx.held_idx != MINE);
		hungry_m = mark || hungry_q || now;
		rn       = (({1'b0, ctx.t} + 17'd1) >= {1'b0, arr_q}) && work;

		tok_n         = tok_i;
		tok_n.any_run = tok_i.any_run || rn;
		tok_n.multi   = tok_i.multi || (tok_i.any_run && rn);
		tok_n.all_fin = tok_i.all_fin && !work;
		// A slot arriving exactly now takes an empty candidate place.
		if (now && tok_n.idx == '0) begin
			tok_n.idx = MINE;
			tok_n.lvl = lvl_q;
		end
		if (arrived && work && !ctx.held) begin
			if (tok_n.idx == '0) begin
				tok_n.idx = MINE;
				tok_n.lvl = lvl_q;
			end else if (tok_n.lvl > lvl_q && hungry_m) begin
				tok_n.idx = MINE;
				tok_n.lvl = lvl_q;
			end
		end
	end

	always_comb begin
		load_hit = load.we && (mlfq_pkg::IDX_W'(load.slot) == MINE);
		sel      = run.go && (run.idx == MINE);
		rem_n    = work ? rem_q - 1'b1 : '0;
		slice_n  = slice_q + 1'b1;
		yield_c  = (slice_n == (mlfq_pkg::SLICE_W'(1) << lvl_q)) || (rem_n == '0);
		demote   = run.multi && (lvl_q < mlfq_pkg::LVL_W'(TOP_LEVEL));
		yield_o  = sel && yield_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arr_q    <= '0;
			rem_q    <= '0;
			lvl_q    <= '0;
			slice_q  <= '0;
			hungry_q <= 1'b0;
		end else if (load_hit) begin
			arr_q    <= load.arrival;
			rem_q    <= load.burst;
			lvl_q    <= '0;
			slice_q  <= '0;
			hungry_q <= 1'b0;
		end else if (tok_vld_i) begin
			hungry_q <= hungry_m;
			if (mark) begin
				slice_q <= '0;
			end
		end else if (sel) begin
			rem_q    <= rem_n;
			hungry_q <= 1'b0;
			if (yield_c) begin
				slice_q <= '0;
				if (demote) begin
					lvl_q <= lvl_q + 1'b1;
				end
			end else begin
				slice_q <= slice_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld_i) begin
			tok_q <= tok_n;
		end
	end

	assign tok_vld_o = vld_q;
	assign tok_o     = tok_q;

endmodule

// ===== sv/multilevel_feedback_tick_scheduler_unit.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid, in_stall   | command, slot, arrival_time, burst_length
// out     | output    | out_valid, out_stall | run_valid, run_slot, all_done, tick_time
//
// A load command is accepted and its all-zero result registered in ST_PUSH. A tick command
// sends a scan token along the row of slot cells, one cell per cycle, then ST_RUN applies
// the run step to the chosen cell; ST_PUSH and ST_RUN wait while a held result is stalled.
// The input is stalled while a command is in progress; one item is handled at a time.
// The result register lets a new command be accepted while an earlier result waits.
// Asynchronous active-low reset clears every slot, the held slot and the time.
module multilevel_feedback_tick_scheduler_unit #(
	parameter int SLOTS     = mlfq_pkg::SLOTS_DEF,
	parameter int TOP_LEVEL = mlfq_pkg::TOP_LEVEL_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [mlfq_pkg::SLOT_W-1:0]   slot,
	input  logic [mlfq_pkg::TIME_W-1:0]   arrival_time,
	input  logic [mlfq_pkg::WORK_W-1:0]   burst_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          run_valid,
	output logic [mlfq_pkg::SLOT_W-1:0]   run_slot,
	output logic                          all_done,
	output logic [mlfq_pkg::TIME_W-1:0]   tick_time
);

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

	state_t                          state_q;
	logic                            cpu_held_q;
	logic [mlfq_pkg::IDX_W-1:0]      held_idx_q;
	logic [mlfq_pkg::TIME_W-1:0]     time_q;

	logic                            out_valid_q;
	logic                            run_valid_q;
	logic [mlfq_pkg::SLOT_W-1:0]     run_slot_q;
	logic                            all_done_q;
	logic [mlfq_pkg::TIME_W-1:0]     tick_time_q;

	logic                            accept, out_free, commit, push, yield_any;
	mlfq_pkg::tok_t                  tok  [0:SLOTS];
	logic                            vld  [0:SLOTS];
	logic [SLOTS-1:0]                yield_vec;
	mlfq_pkg::ctx_t                  ctx;
	mlfq_pkg::load_t                 load;
	mlfq_pkg::run_t                  run;
	mlfq_pkg::tok_t                  fin;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The tick context stays still from acceptance until the run step.
	assign ctx.held     = cpu_held_q;
	assign ctx.held_idx = held_idx_q;
	assign ctx.t        = time_q;

	assign load.we      = accept && (command == mlfq_pkg::CMD_LOAD);
	assign load.slot    = slot;
	assign load.arrival = arrival_time;
	assign load.burst   = burst_length;

	// The scan token enters the first cell in the cycle the tick is accepted. A held CPU
	// starts the scan with the held slot as the candidate.
	always_comb begin
		tok[0].idx     = cpu_held_q ? held_idx_q : '0;
		tok[0].lvl     = '0;
		tok[0].any_run = 1'b0;
		tok[0].multi   = 1'b0;
		tok[0].all_fin = 1'b1;
	end
	assign vld[0] = accept && (command == mlfq_pkg::CMD_TICK);

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			mlfq_cell #(
				.TOP_LEVEL (TOP_LEVEL),
				.IDX       (g + 1)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.tok_vld_i (vld[g]),
				.tok_i     (tok[g]),
				.ctx       (ctx),
				.load      (load),
				.run       (run),
				.tok_vld_o (vld[g+1]),
				.tok_o     (tok[g+1]),
				.yield_o   (yield_vec[g])
			);
		end
	endgenerate

	// The last cell's token holds the tick's outcome until the next scan.
	assign fin       = tok[SLOTS];
	assign commit    = (state_q == ST_RUN) && out_free;
	assign push      = (state_q == ST_PUSH) && out_free;
	assign run.go    = commit && (fin.idx != '0);
	assign run.idx   = fin.idx;
	assign run.multi = fin.multi;
	assign yield_any = |yield_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cpu_held_q <= 1'b0;
			held_idx_q <= '0;
			time_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == mlfq_pkg::CMD_LOAD) begin
							// Reloading the held slot releases the CPU.
							if (cpu_held_q &&
							    held_idx_q == mlfq_pkg::IDX_W'(slot)) begin
								cpu_held_q <= 1'b0;
							end
							state_q <= ST_PUSH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (vld[SLOTS]) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (out_free) begin
						held_idx_q <= fin.idx;
						cpu_held_q <= (fin.idx != '0) && !yield_any;
						time_q     <= time_q + 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit || push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			run_valid_q <= (fin.idx != '0);
			run_slot_q  <= fin.idx[mlfq_pkg::SLOT_W-1:0];
			all_done_q  <= fin.all_fin;
			tick_time_q <= time_q;
		end else if (push) begin
			run_valid_q <= 1'b0;
			run_slot_q  <= '0;
			all_done_q  <= 1'b0;
			tick_time_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign run_valid = run_valid_q;
	assign run_slot  = run_slot_q;
	assign all_done  = all_done_q;
	assign tick_time = tick_time_q;

`ifndef SYNTHESIS
	// Only the chosen cell can report a yield.
	a_one_yield: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(yield_vec))
		else $error("more than one cell yielded");

	// A held CPU always names a slot.
	a_held_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cpu_held_q |-> (held_idx_q != '0))
		else $error("CPU held without a slot");

	// The token leaves the chain only while the controller waits for it.
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		vld[SLOTS] |-> (state_q == ST_SCAN))
		else $error("scan token left the chain outside a scan");

	// A tick result that reports a run names a slot.
	a_run_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && run_valid_q) |-> (run_slot_q != '0))
		else $error("run reported without a slot");

	// A committed tick advances the time by one.
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (time_q == $past(time_q) + 1'b1))
		else $error("time did not advance after a tick");
`endif

endmodule
